// ===== hdl/hsvc_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvc_pkg
// Types, constants and helpers shared by the HSV to RGB converter pipeline.
// ----------------------------------------------------------------------------
package hsvc_pkg;

  localparam int HueWidth   = 9;
  localparam int ChanWidth  = 8;
  localparam int QuotWidth  = 4;   // hue / 60 for a 9-bit hue is 0..8
  localparam int RemWidth   = 6;   // hue mod 60
  localparam int ScaleWidth = 16;  // 255 * brightness
  localparam int WeightWidth = 14; // 15360 - k * saturation
  localparam int NumStages  = 6;

  // floor(hue / 60) == (hue * 1093) >> 16 for every 9-bit hue
  localparam int HueRecip      = 1093;
  localparam int HueRecipWidth = 11;
  localparam int HueRecipShift = 16;

  // floor(y / 60) == (y * 69906) >> 22 for y below 2^16
  localparam int DivRecip      = 69906;
  localparam int DivRecipWidth = 17;
  localparam int DivRecipShift = 22;

  localparam int SectorDeg  = 60;
  localparam int WeightFull = 15360;  // 60 * 256

  typedef logic [2:0] sector_t;

  localparam sector_t Sector0 = 3'd0;
  localparam sector_t Sector1 = 3'd1;
  localparam sector_t Sector2 = 3'd2;
  localparam sector_t Sector3 = 3'd3;
  localparam sector_t Sector4 = 3'd4;
  localparam sector_t Sector5 = 3'd5;

  typedef struct packed {
    sector_t                 sector;
    logic [RemWidth-1:0]     rem;
    logic [ChanWidth-1:0]    sat;
    logic [ScaleWidth-1:0]   scaled;
  } angle_t;

  typedef struct packed {
    sector_t              sector;
    logic [ChanWidth-1:0] lv;
    logic [ChanWidth-1:0] lp;
    logic [ChanWidth-1:0] lq;
    logic [ChanWidth-1:0] lt;
  } levels_t;

  // quotient hue/60 (0..8) wrapped modulo 6
  function automatic sector_t quot_to_sector(input logic [QuotWidth-1:0] quot);
    sector_t s;
    unique case (quot)
      4'd0:    s = Sector0;
      4'd1:    s = Sector1;
      4'd2:    s = Sector2;
      4'd3:    s = Sector3;
      4'd4:    s = Sector4;
      4'd5:    s = Sector5;
      4'd6:    s = Sector0;
      4'd7:    s = Sector1;
      4'd8:    s = Sector2;
      default: s = Sector0;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/hsvc_pixel_if.sv =====
// ----------------------------------------------------------------------------
// hsvc_pixel_if
// Valid/ready channel carrying one HSV pixel.
// ----------------------------------------------------------------------------
interface hsvc_pixel_if;
  logic                            valid;
  logic                            ready;
  logic [hsvc_pkg::HueWidth-1:0]   hue;
  logic [hsvc_pkg::ChanWidth-1:0]  saturation;
  logic [hsvc_pkg::ChanWidth-1:0]  brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink (input valid, input hue, input saturation, input brightness,
                output ready);
endinterface

// ===== hdl/hsvc_rgb_if.sv =====
// ----------------------------------------------------------------------------
// hsvc_rgb_if
// Valid/ready channel carrying one RGB pixel.
// ----------------------------------------------------------------------------
interface hsvc_rgb_if;
  logic                            valid;
  logic                            ready;
  logic [hsvc_pkg::ChanWidth-1:0]  red;
  logic [hsvc_pkg::ChanWidth-1:0]  green;
  logic [hsvc_pkg::ChanWidth-1:0]  blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== hdl/hsvc_angle.sv =====
// ----------------------------------------------------------------------------
// hsvc_angle
// Two pipeline stages: split the hue into sector and remainder, scale value.
// ----------------------------------------------------------------------------
module hsvc_angle (
  input  logic                            clk,
  input  logic [1:0]                      en,
  input  logic [hsvc_pkg::HueWidth-1:0]   hue,
  input  logic [hsvc_pkg::ChanWidth-1:0]  saturation,
  input  logic [hsvc_pkg::ChanWidth-1:0]  brightness,
  output hsvc_pkg::angle_t                angle
);

  localparam int ProdWidth = hsvc_pkg::HueWidth + hsvc_pkg::HueRecipWidth;

  logic [ProdWidth-1:0]                 quot_prod;
  logic [hsvc_pkg::HueWidth-1:0]        hue0;
  logic [hsvc_pkg::QuotWidth-1:0]       quot0;
  logic [hsvc_pkg::ChanWidth-1:0]       sat0;
  logic [hsvc_pkg::ScaleWidth-1:0]      scaled0;
  logic [hsvc_pkg::HueWidth-1:0]        rem_full;

  assign quot_prod = ProdWidth'(hue) *
                     ProdWidth'(hsvc_pkg::HueRecip);

  // stage 0: quotient by reciprocal, 255*v as shift minus value
  always_ff @(posedge clk) begin
    if (en[0]) begin
      hue0    <= hue;
      quot0   <= quot_prod[hsvc_pkg::HueRecipShift +: hsvc_pkg::QuotWidth];
      sat0    <= saturation;
      scaled0 <= {brightness, {hsvc_pkg::ChanWidth{1'b0}}} -
                 hsvc_pkg::ScaleWidth'(brightness);
    end
  end

  assign rem_full = hue0 - hsvc_pkg::HueWidth'(quot0) *
                    hsvc_pkg::HueWidth'(hsvc_pkg::SectorDeg);

  // stage 1: remainder and wrapped sector
  always_ff @(posedge clk) begin
    if (en[1]) begin
      angle.sector <= hsvc_pkg::quot_to_sector(quot0);
      angle.rem    <= rem_full[hsvc_pkg::RemWidth-1:0];
      angle.sat    <= sat0;
      angle.scaled <= scaled0;
    end
  end

endmodule

// ===== hdl/hsvc_levels.sv =====
// ----------------------------------------------------------------------------
// hsvc_levels
// Three pipeline stages forming the blend levels v, p, q and t.
// ----------------------------------------------------------------------------
module hsvc_levels (
  input  logic              clk,
  input  logic [2:0]        en,
  input  hsvc_pkg::angle_t  angle,
  output hsvc_pkg::levels_t levels
);

  localparam int CW  = hsvc_pkg::ChanWidth;
  localparam int SW  = hsvc_pkg::ScaleWidth;
  localparam int WW  = hsvc_pkg::WeightWidth;
  localparam int RW  = hsvc_pkg::RemWidth;
  localparam int PW  = SW + CW + 1;          // scaled * (256 - sat)
  localparam int XW  = SW + WW;              // scaled * weight
  localparam int YW  = XW - SW;              // weight product >> 16
  localparam int DW  = YW + hsvc_pkg::DivRecipWidth;
  localparam int KW  = RW + CW;              // rem * sat

  // stage 2 signals
  logic [PW-1:0]        p_prod;
  logic [KW-1:0]        rq_prod;
  logic [KW-1:0]        rt_prod;
  hsvc_pkg::sector_t    sector2;
  logic [SW-1:0]        scaled2;
  logic [CW-1:0]        lv2;
  logic [CW-1:0]        lp2;
  logic [WW-1:0]        wq2;
  logic [WW-1:0]        wt2;

  // stage 3 signals
  logic [XW-1:0]        xq;
  logic [XW-1:0]        xt;
  hsvc_pkg::sector_t    sector3;
  logic [CW-1:0]        lv3;
  logic [CW-1:0]        lp3;
  logic [YW-1:0]        yq3;
  logic [YW-1:0]        yt3;

  // stage 4 signals
  logic [DW-1:0]        dq;
  logic [DW-1:0]        dt;

  assign p_prod  = PW'(angle.scaled) * (PW'(1 << CW) - PW'(angle.sat));
  assign rq_prod = KW'(angle.rem) * KW'(angle.sat);
  assign rt_prod = (KW'(hsvc_pkg::SectorDeg) - KW'(angle.rem)) * KW'(angle.sat);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sector2 <= angle.sector;
      scaled2 <= angle.scaled;
      lv2     <= angle.scaled[SW-1 -: CW];
      lp2     <= p_prod[SW +: CW];
      wq2     <= WW'(hsvc_pkg::WeightFull) - WW'(rq_prod);
      wt2     <= WW'(hsvc_pkg::WeightFull) - WW'(rt_prod);
    end
  end

  assign xq = XW'(scaled2) * XW'(wq2);
  assign xt = XW'(scaled2) * XW'(wt2);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sector3 <= sector2;
      lv3     <= lv2;
      lp3     <= lp2;
      yq3     <= xq[SW +: YW];
      yt3     <= xt[SW +: YW];
    end
  end

  // divide by 60 through the reciprocal; quotient never exceeds 254
  assign dq = DW'(yq3) * DW'(hsvc_pkg::DivRecip);
  assign dt = DW'(yt3) * DW'(hsvc_pkg::DivRecip);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      levels.sector <= sector3;
      levels.lv     <= lv3;
      levels.lp     <= lp3;
      levels.lq     <= dq[hsvc_pkg::DivRecipShift +: CW];
      levels.lt     <= dt[hsvc_pkg::DivRecipShift +: CW];
    end
  end

endmodule

// ===== hdl/hsv_to_rgb_converter_core.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// Pipelined HSV to RGB pixel converter with valid/ready channels.
// ----------------------------------------------------------------------------
// Usage:
//   pixel carries hue (0..359 degrees, larger codes wrap by sector),
//   saturation and brightness (code/256). color carries red, green, blue.
//   A transaction completes on a rising edge with valid and ready high.
//   Six register stages lie between pixel and color. One pixel per
//   cycle is sustained; the rate is set by the output register being
//   free or taken. Each stage has its own valid bit and advances when it
//   is empty or the stage after it advances, so bubbles are squeezed out
//   while color is stalled; pixel.ready drops only once all six stages
//   hold a pixel.
//   A stall holds every pixel in place: nothing is lost or repeated.
//   Synchronous reset (rst) empties the pipeline; color.valid is low in
//   the cycle after reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core (
  input  logic       clk,
  input  logic       rst,
  hsvc_pixel_if.sink pixel,
  hsvc_rgb_if.source color
);

  localparam int NS = hsvc_pkg::NumStages;

  logic [NS-1:0]      vld;
  logic [NS-1:0]      en;
  hsvc_pkg::angle_t   angle;
  hsvc_pkg::levels_t  levels;

  always_comb begin
    en[NS-1] = !vld[NS-1] || color.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= pixel.valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  assign pixel.ready = en[0];

  hsvc_angle u_angle (
    .clk        (clk),
    .en         (en[1:0]),
    .hue        (pixel.hue),
    .saturation (pixel.saturation),
    .brightness (pixel.brightness),
    .angle      (angle)
  );

  hsvc_levels u_levels (
    .clk    (clk),
    .en     (en[4:2]),
    .angle  (angle),
    .levels (levels)
  );

  // output stage: place the levels on the channels by sector
  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      unique case (levels.sector)
        hsvc_pkg::Sector0: begin
          color.red <= levels.lp; color.green <= levels.lq; color.blue <= levels.lv;
        end
        hsvc_pkg::Sector1: begin
          color.red <= levels.lt; color.green <= levels.lp; color.blue <= levels.lv;
        end
        hsvc_pkg::Sector2: begin
          color.red <= levels.lv; color.green <= levels.lp; color.blue <= levels.lq;
        end
        hsvc_pkg::Sector3: begin
          color.red <= levels.lv; color.green <= levels.lt; color.blue <= levels.lp;
        end
        hsvc_pkg::Sector4: begin
          color.red <= levels.lq; color.green <= levels.lv; color.blue <= levels.lp;
        end
        default: begin
          color.red <= levels.lp; color.green <= levels.lv; color.blue <= levels.lt;
        end
      endcase
    end
  end

  assign color.valid = vld[NS-1];

`ifndef SYNTHESIS
  // input is refused only when every stage holds a pixel
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !pixel.ready |-> (&vld))
    else $error("input stalled with an empty pipeline stage");

  // a pixel behind a stalled output stays put
  a_hold_behind_stall: assert property (@(posedge clk) disable iff (rst)
    (vld[NS-1] && !color.ready && vld[NS-2]) |=> (vld[NS-1] && vld[NS-2]))
    else $error("pixel dropped while output stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!color.valid && vld == '0))
    else $error("pipeline not empty after reset");
`endif

endmodule
